[design/etp_pkg.sv]
// exclusive time profiler package: request/response types, opcodes, status codes
// and default sizes; no dependencies
package etp_pkg;

   localparam int unsigned OP_W = 2;
   localparam int unsigned ID_W = 5;
   localparam int unsigned TS_W = 32;
   localparam int unsigned ST_W = 2;

   localparam int unsigned NumFuncsDef   = 32;
   localparam int unsigned StackDepthDef = 64;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_END   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [ST_W-1:0] ST_BACKWARDS = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] func;
      logic [ID_W-1:0] fn_id;
      logic [TS_W-1:0] stamp;
   } req_type;

   typedef struct packed {
      logic [TS_W-1:0] total;
      logic [ST_W-1:0] status;
   } rsp_type;

endpackage

[design/etp_ram.sv]
// exclusive time profiler memory: one write port, one read port, registered read data
// no dependencies
module etp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/exclusive_time_profiler.sv]
// exclusive time profiler top: sequencer, call stack and totals memories
// depends on etp_pkg and etp_ram
//
// One request is taken at a time, in this order: a call stack read of the top entry, a
// totals read at the top id (or at fn_id for a read), then the saturating add and write
// back with the push or pop. busy is high in S_TOP and S_RMW after acceptance, so a new
// request is accepted only once the previous one has been written back. The response
// strobe rsp_valid rises in the cycle after the write back and lasts one cycle; it
// cannot be held off, so the receiver must take it. After reset the totals memory is
// cleared one entry a cycle, all NUM_FUNCS entries, with busy high.
module exclusive_time_profiler #(
   parameter int unsigned NUM_FUNCS   = etp_pkg::NumFuncsDef,
   parameter int unsigned STACK_DEPTH = etp_pkg::StackDepthDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  etp_pkg::req_type req_item,
   output logic             rsp_valid,
   output etp_pkg::rsp_type rsp_item
);
   import etp_pkg::*;

   localparam int unsigned FA = $clog2(NUM_FUNCS);
   localparam int unsigned SA = $clog2(STACK_DEPTH);
   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_TOP   = 2'd2;
   localparam logic [1:0] S_RMW   = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [FA-1:0]   clr_ff, clr_in;
   logic [LW-1:0]   level_ff, level_in;
   logic [TS_W-1:0] seg_ff, seg_in;
   logic            rsp_valid_ff, rsp_valid_in;

   req_type         req_ff;
   logic [TS_W:0]   amount_ff, amount_in;
   logic [ST_W-1:0] status_ff, status_in;
   logic            charge_ff, charge_in;
   logic            in_range_ff, in_range_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept;
   logic            full;
   logic            empty;
   logic [ID_W-1:0] top_id;
   logic [ID_W-1:0] sel_id;
   logic [TS_W:0]   stamp_x;
   logic [TS_W:0]   stamp_p1;
   logic [TS_W:0]   seg_x;
   logic [TS_W+1:0] sum;
   logic [TS_W-1:0] sat_sum;
   logic [TS_W-1:0] tot_rd;

   logic            stk_we;
   logic [SA-1:0]   stk_waddr;
   logic [SA-1:0]   stk_raddr;
   logic            tot_we;
   logic [FA-1:0]   tot_waddr;
   logic [TS_W-1:0] tot_wdata;
   logic [FA-1:0]   tot_raddr;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign full   = (level_ff == LW'(STACK_DEPTH));
   assign empty  = (level_ff == '0);

   // call stack
   assign stk_raddr = SA'(level_ff - LW'(1));
   assign stk_we    = (state_ff == S_RMW) && (req_ff.func == OP_START) && !full;
   assign stk_waddr = level_ff[SA-1:0];

   etp_ram #(.WIDTH(ID_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (req_ff.fn_id),
      .rd_addr (stk_raddr),
      .rd_data (top_id)
   );

   // totals
   assign sel_id    = (req_ff.func == OP_READ) ? req_ff.fn_id : top_id;
   assign tot_raddr = FA'(sel_id);
   assign sum       = {2'b00, tot_rd} + {1'b0, amount_ff};
   assign sat_sum   = (sum[TS_W+1:TS_W] != 2'b00) ? '1 : sum[TS_W-1:0];

   always_comb begin
      if (state_ff == S_CLEAR) begin
         tot_we    = 1'b1;
         tot_waddr = clr_ff;
         tot_wdata = '0;
      end else begin
         tot_we    = (state_ff == S_RMW) && charge_ff;
         tot_waddr = FA'(top_id);
         tot_wdata = sat_sum;
      end
   end

   etp_ram #(.WIDTH(TS_W), .DEPTH(NUM_FUNCS)) u_totals (
      .clock   (clock),
      .wr_en   (tot_we),
      .wr_addr (tot_waddr),
      .wr_data (tot_wdata),
      .rd_addr (tot_raddr),
      .rd_data (tot_rd)
   );

   // charge amount and status, worked out while the total is read
   assign stamp_x  = {1'b0, req_ff.stamp};
   assign stamp_p1 = stamp_x + (TS_W+1)'(1);
   assign seg_x    = {1'b0, seg_ff};

   always_comb begin
      amount_in   = '0;
      status_in   = ST_OK;
      charge_in   = 1'b0;
      in_range_in = ({{(32-ID_W){1'b0}}, sel_id} < 32'(NUM_FUNCS));
      case (req_ff.func)
         OP_START: begin
            amount_in = stamp_x - seg_x;
            if (full) begin
               status_in = ST_OVERFLOW;
            end else if (stamp_x < seg_x) begin
               status_in = ST_BACKWARDS;
            end else begin
               charge_in = !empty && in_range_in;
            end
         end
         OP_END: begin
            amount_in = stamp_p1 - seg_x;
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (stamp_p1 < seg_x) begin
               status_in = ST_BACKWARDS;
            end else begin
               charge_in = in_range_in;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      level_in     = level_ff;
      seg_in       = seg_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + FA'(1);
            if (clr_ff == FA'(NUM_FUNCS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_RMW;
         end
         S_RMW: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (req_ff.func == OP_START && !full) begin
               level_in = level_ff + LW'(1);
               seg_in   = req_ff.stamp;
            end else if (req_ff.func == OP_END && !empty) begin
               level_in = level_ff - LW'(1);
               seg_in   = stamp_p1[TS_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.status = status_ff;
      rsp_in.total  = '0;
      if (req_ff.func == OP_READ && in_range_ff) begin
         rsp_in.total = tot_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         level_ff     <= '0;
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         level_ff     <= level_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (state_ff == S_TOP) begin
         amount_ff   <= amount_in;
         status_ff   <= status_in;
         charge_ff   <= charge_in;
         in_range_ff <= in_range_in;
      end
      if (state_ff == S_RMW) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("response missing three cycles after request");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_err_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.total == '0)
      else $error("nonzero total with error status");

endmodule
